// ===== sv/ray_box_intersection_assert.svh =====
// Assertion macros for the ray/box intersection block.
// Bodies expect aclk and aresetn in scope.
`ifndef RAY_BOX_INTERSECTION_ASSERT_SVH
`define RAY_BOX_INTERSECTION_ASSERT_SVH
`ifndef ASSERT_OFF
`define RBI_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rbi: assertion failed");
`define RBI_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("rbi: reset check failed");
`else
`define RBI_ASSERT(label, prop)
`define RBI_ASSERT_RST(label, prop)
`endif
`endif

// ===== sv/rbi_pkg.sv =====
`timescale 1ns / 1ps
package rbi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CW         = 32;
    localparam int AXES       = 3;
    localparam int BOX_W      = 15;
    localparam int FAR_W      = 31;
    localparam int DIST_W     = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam int BOUND_W    = BOX_W + FRAC_BITS;
    localparam int MAG_W      = CW;
    localparam int NUM_W      = MAG_W + FRAC_BITS;
    localparam int DVS_W      = CW;
    localparam int LO_W       = 2 * CW;
    localparam int HI_W       = (NUM_W - CW) + CW;
    localparam int M_W        = 2 * CW - FRAC_BITS + 2;
    localparam int H_W        = M_W + 2;
    localparam int SQ_W       = 2 * DIST_W;
    localparam int SUM_W      = 2 * CW;
    localparam int SQ_STEPS   = CW;
    localparam int CLAMP_EXP  = 41;
    localparam int HI_LIM_EXP = 9 + FRAC_BITS;

    localparam logic [BOX_W-1:0] BOX_SIZE_RESET  = BOX_W'(16);
    localparam logic [FAR_W-1:0] FAR_LIMIT_RESET = FAR_W'(655360);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_SIZE  = 1'b0,
        REG_FAR_LIMIT = 1'b1
    } rbi_reg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
    } rbi_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] hit_distance;
        logic              hit_valid;
    } rbi_out_t;

    // per-axis ray data riding alongside the divider
    typedef struct packed {
        logic signed [CW-1:0] org;
        logic signed [CW-1:0] dir;
        logic [MAG_W-1:0]     pmag;  // |plane - origin|
        logic                 live;  // outside on this axis, nonzero dir
        logic                 neg;   // plane - origin and dir differ in sign
    } rbi_axis_t;

    typedef struct packed {
        rbi_axis_t [AXES-1:0] ax;
        logic                 in_box;
    } rbi_ray_t;

    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [NUM_W-1:0] acc;   // dividend in, quotient out
        logic [DVS_W-1:0] dvs;
    } rbi_div_lane_t;

    typedef rbi_div_lane_t [AXES-1:0] rbi_lanes_t;

    typedef struct packed {
        logic miss;
        logic in_box;
    } rbi_sq_side_t;

    // one restoring division step
    function automatic rbi_div_lane_t rbi_div_step(input rbi_div_lane_t l);
        rbi_div_lane_t     r;
        logic [DVS_W:0]    trial;
        logic              qb;
        trial = {l.rem, l.acc[NUM_W-1]};
        qb    = (trial >= {1'b0, l.dvs});
        r.dvs = l.dvs;
        r.rem = qb ? DVS_W'(trial - {1'b0, l.dvs}) : trial[DVS_W-1:0];
        r.acc = {l.acc[NUM_W-2:0], qb};
        return r;
    endfunction

endpackage

// ===== sv/ray_box_intersection.sv =====
`timescale 1ns / 1ps
// Ray versus cube [0, box_size] intersection in signed Q16.16. Takes one ray
// per cycle and returns one item per ray, in order, through 89 register
// stages: one input stage, a 49-stage bit-serial-per-stage
// divider for the three plane distances,
// five stages of select / multiply / range check / square / sum, a 33-stage
// square root, and the output register. The whole pipeline advances whenever
// the output register is empty or being taken, so with m_ready held high the
// block sustains one ray per cycle. hit_valid is set when the origin lies in
// the cube (distance 0) or the entry point lies within far_limit; a miss gives
// distance 0. Write box_size and far_limit only while the pipeline is empty.
module ray_box_intersection (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rbi_pkg::rbi_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rbi_pkg::rbi_out_t             m_data,
    input  logic                          cfg_wr_en,
    input  logic [rbi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rbi_pkg::*;

    // ---------------- config ----------------
    logic [BOX_W-1:0] box_size_reg;
    logic [FAR_W-1:0] far_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_size_reg  <= BOX_SIZE_RESET;
            far_limit_reg <= FAR_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (rbi_reg_idx_t'(cfg_index))
                REG_BOX_SIZE:  box_size_reg  <= cfg_wdata[BOX_W-1:0];
                REG_FAR_LIMIT: far_limit_reg <= cfg_wdata[FAR_W-1:0];
                default: ;
            endcase
        end
    end

    logic [BOUND_W-1:0] bound;
    assign bound = BOUND_W'(box_size_reg) << FRAC_BITS;

    // global advance: everything moves when the output slot frees up
    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------- stage A: input register ----------------
    logic    a_valid_reg;
    rbi_in_t a_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
        if (adv) begin
            a_data_reg <= s_data;
        end
    end

    // classify each axis and set up the divisions
    logic signed [CW-1:0] a_org [AXES];
    logic signed [CW-1:0] a_dir [AXES];
    rbi_lanes_t           div_in;
    rbi_ray_t             div_side;

    assign a_org[0] = a_data_reg.origin_x;
    assign a_org[1] = a_data_reg.origin_y;
    assign a_org[2] = a_data_reg.origin_z;
    assign a_dir[0] = a_data_reg.dir_x;
    assign a_dir[1] = a_data_reg.dir_y;
    assign a_dir[2] = a_data_reg.dir_z;

    always_comb begin
        logic below;
        logic above;
        logic [MAG_W-1:0] pmag;
        div_side.in_box = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            below = a_org[i][CW-1];
            above = !below && (CW'(a_org[i]) > CW'(bound));
            // below: plane 0; above: plane at bound (origin past it)
            pmag  = below ? MAG_W'(-a_org[i]) : MAG_W'(a_org[i]) - MAG_W'(bound);
            div_side.ax[i].org  = a_org[i];
            div_side.ax[i].dir  = a_dir[i];
            div_side.ax[i].pmag = pmag;
            div_side.ax[i].live = (below || above) && (a_dir[i] != '0);
            div_side.ax[i].neg  = above ^ a_dir[i][CW-1];
            if (below || above) begin
                div_side.in_box = 1'b0;
            end
            div_in[i].rem = '0;
            div_in[i].acc = {pmag, {FRAC_BITS{1'b0}}};
            div_in[i].dvs = a_dir[i][CW-1] ? DVS_W'(-a_dir[i]) : DVS_W'(a_dir[i]);
        end
    end

    logic       div_valid;
    rbi_lanes_t div_out;
    rbi_ray_t   div_ray;

    rbi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (a_valid_reg),
        .in_lanes  (div_in),
        .in_side   (div_side),
        .out_valid (div_valid),
        .out_lanes (div_out),
        .out_side  (div_ray)
    );

    // ---------------- stage C: pick the largest plane distance ----------------
    logic             c_valid_reg;
    logic [NUM_W-1:0] c_tsel_reg;
    logic [1:0]       c_best_reg;
    logic             c_miss_reg;
    logic             c_inside_reg;
    rbi_axis_t        c_ax_reg [AXES];

    logic [1:0]       c_best_next;
    logic             c_tv [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            // t >= 0 when signs agree, or when the quotient truncates to zero
            c_tv[i] = div_ray.ax[i].live &&
                      (!div_ray.ax[i].neg || (div_out[i].acc == '0));
        end
        c_best_next = 2'd0;
        for (int i = 1; i < AXES; i++) begin
            if (c_tv[i] && (!c_tv[c_best_next] ||
                            (div_out[c_best_next].acc < div_out[i].acc))) begin
                c_best_next = 2'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= div_valid;
        end
        if (adv) begin
            c_tsel_reg   <= div_out[c_best_next].acc;
            c_best_reg   <= c_best_next;
            c_miss_reg   <= !c_tv[c_best_next];
            c_inside_reg <= div_ray.in_box;
            for (int i = 0; i < AXES; i++) begin
                c_ax_reg[i] <= div_ray.ax[i];
            end
        end
    end

    // ---------------- stage D: t * |dir| as two partial products ----------------
    logic             d_valid_reg;
    logic [LO_W-1:0]  d_lo_reg [AXES];
    logic [HI_W-1:0]  d_hi_reg [AXES];
    logic [1:0]       d_best_reg;
    logic             d_miss_reg;
    logic             d_inside_reg;
    rbi_axis_t        d_ax_reg [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
        if (adv) begin
            for (int i = 0; i < AXES; i++) begin
                logic [CW-1:0] dm;
                dm = c_ax_reg[i].dir[CW-1] ? CW'(-c_ax_reg[i].dir) : CW'(c_ax_reg[i].dir);
                d_lo_reg[i] <= LO_W'(c_tsel_reg[CW-1:0]) * LO_W'(dm);
                d_hi_reg[i] <= HI_W'(c_tsel_reg[NUM_W-1:CW]) * HI_W'(dm);
                d_ax_reg[i] <= c_ax_reg[i];
            end
            d_best_reg   <= c_best_reg;
            d_miss_reg   <= c_miss_reg;
            d_inside_reg <= c_inside_reg;
        end
    end

    // ---------------- stage E: hit point check, offset magnitudes ----------------
    logic              e_valid_reg;
    logic [DIST_W-1:0] e_mag_reg [AXES];
    logic              e_miss_reg;
    logic              e_inside_reg;

    logic [DIST_W-1:0] e_mag_next [AXES];
    logic              e_miss_next;

    always_comb begin
        logic [M_W-1:0]        m;
        logic [M_W-1:0]        mag;
        logic signed [H_W-1:0] h;
        e_miss_next = d_miss_reg;
        for (int i = 0; i < AXES; i++) begin
            if (d_hi_reg[i] >= (HI_W'(1) << HI_LIM_EXP)) begin
                m = M_W'(1) << CLAMP_EXP;
            end else begin
                m = (M_W'(d_hi_reg[i]) << (CW - FRAC_BITS)) +
                    M_W'(d_lo_reg[i] >> FRAC_BITS);
            end
            h = d_ax_reg[i].dir[CW-1] ?
                H_W'(d_ax_reg[i].org) - $signed(H_W'(m)) :
                H_W'(d_ax_reg[i].org) + $signed(H_W'(m));
            if (2'(i) == d_best_reg) begin
                mag = M_W'(d_ax_reg[i].pmag);
            end else begin
                mag = m;
                if (h < 0 || h > $signed(H_W'(bound))) begin
                    e_miss_next = 1'b1;
                end
            end
            // an offset of 2^31 or more can never be within range
            if (mag[M_W-1:DIST_W] != '0) begin
                e_miss_next = 1'b1;
            end
            e_mag_next[i] = mag[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= d_valid_reg;
        end
        if (adv) begin
            for (int i = 0; i < AXES; i++) begin
                e_mag_reg[i] <= e_mag_next[i];
            end
            e_miss_reg   <= e_miss_next;
            e_inside_reg <= d_inside_reg;
        end
    end

    // ---------------- stage F: squares ----------------
    logic            f_valid_reg;
    logic [SQ_W-1:0] f_sq_reg [AXES];
    rbi_sq_side_t    f_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= e_valid_reg;
        end
        if (adv) begin
            for (int i = 0; i < AXES; i++) begin
                f_sq_reg[i] <= SQ_W'(e_mag_reg[i]) * SQ_W'(e_mag_reg[i]);
            end
            f_side_reg.miss   <= e_miss_reg;
            f_side_reg.in_box <= e_inside_reg;
        end
    end

    // ---------------- stage G: sum of squares ----------------
    logic             g_valid_reg;
    logic [SUM_W-1:0] g_sum_reg;
    rbi_sq_side_t     g_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (adv) begin
            g_valid_reg <= f_valid_reg;
        end
        if (adv) begin
            g_sum_reg  <= SUM_W'(f_sq_reg[0]) + SUM_W'(f_sq_reg[1]) + SUM_W'(f_sq_reg[2]);
            g_side_reg <= f_side_reg;
        end
    end

    // ---------------- square root ----------------
    logic          sq_valid;
    logic [CW-1:0] sq_root;
    rbi_sq_side_t  sq_side;

    rbi_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (g_valid_reg),
        .in_sum    (g_sum_reg),
        .in_side   (g_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- output register ----------------
    rbi_out_t m_data_reg;
    rbi_out_t m_data_next;

    always_comb begin
        logic hit;
        hit = !sq_side.miss && (sq_root <= CW'(far_limit_reg));
        m_data_next.hit_valid    = sq_side.in_box || hit;
        // inside reports zero distance whatever the later stages computed
        m_data_next.hit_distance = (!sq_side.in_box && hit) ? sq_root[DIST_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= sq_valid;
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- checks ----------------
`include "ray_box_intersection_assert.svh"

    `RBI_ASSERT(a_miss_zero_dist, m_valid |-> (m_data.hit_valid || m_data.hit_distance == '0))
    `RBI_ASSERT(a_hit_in_range, m_valid && m_data.hit_valid |-> m_data.hit_distance <= far_limit_reg)
    `RBI_ASSERT(a_out_from_pipe, $rose(m_valid) |-> $past(sq_valid && adv))
    `RBI_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid)

endmodule

// ===== sv/rbi_div.sv =====
`timescale 1ns / 1ps
// Three-lane pipelined restoring divider, one quotient bit per stage.
module rbi_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  rbi_pkg::rbi_lanes_t in_lanes,
    input  rbi_pkg::rbi_ray_t   in_side,
    output logic              out_valid,
    output rbi_pkg::rbi_lanes_t out_lanes,
    output rbi_pkg::rbi_ray_t   out_side
);
    import rbi_pkg::*;

    logic       vld_reg  [NUM_W+1];
    rbi_lanes_t lane_reg [NUM_W+1];
    rbi_ray_t   side_reg [NUM_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
        if (adv) begin
            lane_reg[0] <= in_lanes;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= NUM_W; k++) begin : g_step
        rbi_lanes_t lane_next;
        always_comb begin
            for (int i = 0; i < AXES; i++) begin
                lane_next[i] = rbi_div_step(lane_reg[k-1][i]);
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (adv) begin
                lane_reg[k] <= lane_next;
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign out_lanes = lane_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];

endmodule

// ===== sv/rbi_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module rbi_sqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [rbi_pkg::SUM_W-1:0] in_sum,
    input  rbi_pkg::rbi_sq_side_t    in_side,
    output logic                     out_valid,
    output logic [rbi_pkg::CW-1:0]   out_root,
    output rbi_pkg::rbi_sq_side_t    out_side
);
    import rbi_pkg::*;

    logic              vld_reg  [SQ_STEPS+1];
    logic [SUM_W-1:0]  v_reg    [SQ_STEPS+1];
    logic [SUM_W-1:0]  res_reg  [SQ_STEPS+1];
    rbi_sq_side_t      side_reg [SQ_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
        if (adv) begin
            v_reg[0]    <= in_sum;
            res_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * s);
        logic [SUM_W-1:0] trial;
        logic [SUM_W-1:0] v_next;
        logic [SUM_W-1:0] res_next;
        always_comb begin
            trial = res_reg[s] + BIT;
            if (v_reg[s] >= trial) begin
                v_next   = v_reg[s] - trial;
                res_next = (res_reg[s] >> 1) + BIT;
            end else begin
                v_next   = v_reg[s];
                res_next = res_reg[s] >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[s+1] <= vld_reg[s];
            end
            if (adv) begin
                v_reg[s+1]    <= v_next;
                res_reg[s+1]  <= res_next;
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[SQ_STEPS];
    assign out_root  = res_reg[SQ_STEPS][CW-1:0];
    assign out_side  = side_reg[SQ_STEPS];

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import rbi_pkg::*;

    localparam int DRAIN_CYCLES = 120;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    rbi_in_t s_data;
    logic m_valid;
    logic m_ready;
    rbi_out_t m_data;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ray_box_intersection dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predictor's copy of the registers
    logic [BOX_W-1:0] cur_box;
    logic [FAR_W-1:0] cur_far;

    rbi_out_t hit_queue[$];
    int       n_errors;
    int       n_checked;
    int       n_hits;
    bit       quiet;      // no idling in the final stretch

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // t * d >> FRAC_BITS on magnitudes, clamped at 2^41
    function automatic longint scaled_offset(input longint t, input longint d);
        logic [63:0] mt, md, lo, hi, m;
        mt = mag(t);
        md = mag(d);
        lo = {32'b0, mt[31:0]} * md;
        hi = (mt >> 32) * md;
        if (hi >= (64'd1 << HI_LIM_EXP))
            m = 64'd1 << CLAMP_EXP;
        else
            m = (hi << (32 - FRAC_BITS)) + (lo >> FRAC_BITS);
        return ((t < 0) != (d < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic rbi_out_t predict_hit(input rbi_in_t r);
        rbi_out_t res;
        longint o[3], d[3], pl[3], t[3], df[3];
        longint bound, h;
        logic [63:0] sum, m, root;
        bit in_box, outside[3];
        int best;
        res = '0;
        bound = longint'(cur_box) << FRAC_BITS;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
        in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            pl[i] = 0;
            outside[i] = 1'b0;
            if (o[i] < 0) begin
                outside[i] = 1'b1;
                in_box = 1'b0;
            end else if (o[i] > bound) begin
                outside[i] = 1'b1;
                pl[i] = bound;
                in_box = 1'b0;
            end
        end
        if (in_box) begin
            res.hit_valid = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++)
            t[i] = (outside[i] && d[i] != 0) ? ((pl[i] - o[i]) <<< FRAC_BITS) / d[i]
                                             : -(longint'(1) << FRAC_BITS);
        best = 0;
        for (int i = 1; i < 3; i++)
            if (t[best] < t[i]) best = i;
        if (t[best] < 0) return res;
        for (int i = 0; i < 3; i++) begin
            if (i == best) begin
                df[i] = pl[i] - o[i];
            end else begin
                df[i] = scaled_offset(t[best], d[i]);
                h = o[i] + df[i];
                if (h < 0 || h > bound) return res;
            end
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m = mag(df[i]);
            if (m >= (64'd1 << 31)) return res;
            sum = sum + m * m;
        end
        root = int_sqrt(sum);
        if (root > cur_far) return res;
        res.hit_distance = root[DIST_W-1:0];
        res.hit_valid = 1'b1;
        return res;
    endfunction

    task automatic write_reg(input rbi_reg_idx_t idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BOX_SIZE) cur_box = val[BOX_W-1:0];
        else cur_far = val[FAR_W-1:0];
        @(posedge aclk);
    endtask

    // wait for pipeline empty before touching registers
    task automatic drain;
        int guard;
        guard = 0;
        while (hit_queue.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // send one ray; pushes expectation at accept; optional typed check
    task automatic send_ray(input rbi_in_t r, input bit fixed, input rbi_out_t want);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hit_queue.push_back(fixed ? want : predict_hit(r));
    endtask

    task automatic stop_sending;
        s_valid <= 1'b0;
    endtask

    // receiver: random stall bursts
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 12);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        rbi_out_t exp_hit;
        if (aresetn && m_valid && m_ready) begin
            if (hit_queue.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected item %p", m_data);
            end else begin
                exp_hit = hit_queue.pop_front();
                n_checked++;
                if (m_data.hit_valid) n_hits++;
                if (m_data.hit_distance !== exp_hit.hit_distance ||
                    m_data.hit_valid !== exp_hit.hit_valid) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp dist %0d valid %0b, got dist %0d valid %0b",
                                 exp_hit.hit_distance, exp_hit.hit_valid,
                                 m_data.hit_distance, m_data.hit_valid);
                end
            end
        end
    end

    function automatic rbi_in_t mk_ray(input int ox, oy, oz, dx, dy, dz);
        rbi_in_t r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        return r;
    endfunction

    // a coordinate near the box, sometimes wild
    function automatic int coord;
        int b;
        b = int'(cur_box) << FRAC_BITS;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, b);
            2: return -int'($urandom_range(0, 2 * b + 65536));
            3: return b + int'($urandom_range(0, 2 * b + 65536));
            4: return ($urandom_range(0, 1) ? 0 : b);
            default: return int'($urandom_range(0, 3 * b)) - b;
        endcase
    endfunction

    function automatic int dir_comp;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 0;
            2: return int'($urandom_range(0, 131072)) - 65536;
            default: return int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
        endcase
    endfunction

    typedef struct {
        rbi_in_t  ray;
        bit       fixed;
        rbi_out_t want;
    } stim_row_t;

    initial begin
        stim_row_t rows[$];
        rbi_out_t  inside_hit, miss_hit;
        int        n_rays;
        int        b;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn = 1'b0;
        n_errors = 0;
        n_checked = 0;
        n_hits = 0;
        quiet = 1'b0;
        n_rays = 0;
        cur_box = BOX_SIZE_RESET;
        cur_far = FAR_LIMIT_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        inside_hit = '{hit_distance: '0, hit_valid: 1'b1};
        miss_hit   = '{hit_distance: '0, hit_valid: 1'b0};
        b = 16 << FRAC_BITS;
        // directed part, reset registers (box 16 m, far 10 m)
        rows = '{
            '{mk_ray(0, 0, 0, 0, 0, 0), 1, inside_hit},            // corner, on face
            '{mk_ray(b, b, b, 1, 1, 1), 1, inside_hit},            // far corner
            '{mk_ray(b/2, b/2, b/2, 32'h80000000, 0, 0), 1, inside_hit},
            '{mk_ray(-65536, b/2, b/2, 0, 0, 0), 1, miss_hit},     // zero direction
            '{mk_ray(-65536, b/2, b/2, -65536, 0, 0), 1, miss_hit},// pointing away
            '{mk_ray(-65536, b/2, b/2, 65536, 0, 0), 0, miss_hit}, // 1 m hit
            '{mk_ray(b + 65536, b/2, b/2, -65536, 0, 0), 0, miss_hit},
            '{mk_ray(-65536, -65536, b/2, 65536, 65536, 0), 0, miss_hit},
            '{mk_ray(-65536, b/2, b/2, 65536, 32'h7fffffff, 0), 0, miss_hit},
            '{mk_ray(-65536 * 20, b/2, b/2, 65536, 0, 0), 0, miss_hit}, // beyond far
            '{mk_ray(32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, miss_hit},
            '{mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h80000000), 0, miss_hit},
            '{mk_ray(32'hffffffff, 0, 0, 32'h00000001, 0, 0), 0, miss_hit},
            '{mk_ray(32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'hffffffff, 32'hffffffff, 32'hffffffff), 1, miss_hit},
            '{mk_ray(-65536, -65536, -65536, 65536, 65536, 65536), 0, miss_hit}
        };
        foreach (rows[i]) send_ray(rows[i].ray, rows[i].fixed, rows[i].want);
        stop_sending();
        drain();

        // degenerate box, full far limit
        write_reg(REG_BOX_SIZE, 0);
        write_reg(REG_FAR_LIMIT, 31'h7fffffff);
        send_ray(mk_ray(0, 0, 0, 5, 5, 5), 1, inside_hit);
        send_ray(mk_ray(-65536, 0, 0, 65536, 0, 0), 0, miss_hit);
        send_ray(mk_ray(1, 0, 0, 0, 0, 0), 1, miss_hit);
        stop_sending();
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(REG_BOX_SIZE, 1);     write_reg(REG_FAR_LIMIT, 0); end
                1: begin write_reg(REG_BOX_SIZE, 32767); write_reg(REG_FAR_LIMIT, 31'h7fffffff); end
                2: begin write_reg(REG_BOX_SIZE, 16);    write_reg(REG_FAR_LIMIT, 655360); end
                default: begin
                    write_reg(REG_BOX_SIZE, $urandom_range(1, 64));
                    write_reg(REG_FAR_LIMIT, $urandom_range(0, 31'h7fffffff) >> $urandom_range(0, 12));
                end
            endcase
            if (ph == 5) quiet = 1'b1;
            for (int k = 0; k < 150; k++) begin
                send_ray(mk_ray(coord(), coord(), coord(),
                                dir_comp(), dir_comp(), dir_comp()), 0, miss_hit);
                n_rays++;
                if (ph == 3 && k == 70) begin
                    // hold off until the pipeline has emptied
                    stop_sending();
                    while (hit_queue.size() != 0) @(posedge aclk);
                end
            end
            stop_sending();
            drain();
        end

        $display("checked %0d items (%0d with a hit) over %0d random rays and 8 settings",
                 n_checked, n_hits, n_rays);
        if (n_errors == 0 && hit_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d items outstanding", n_errors, hit_queue.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
